// File: rtl/frps_pkg.sv
// ----------------------------------------------------------------------------
// frps_pkg
// Shared types and constants of the frame rate pacer with timing statistics.
// ----------------------------------------------------------------------------
package frps_pkg;

   // Field widths
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 16;
   localparam int FPS_W   = 10;
   localparam int MIN_W   = 10;

   // Operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   // Timing constants
   localparam logic [TIME_W-1:0]  MS_PER_SEC = 32'd1000;
   localparam logic [TIME_W-1:0]  WINDOW_MS  = 32'd1000;
   localparam logic [MIN_W-1:0]   MIN_RESET  = 10'd1000;
   localparam logic [FPS_W-1:0]   FPS_RESET  = 10'd60;
   localparam logic [FPS_W-1:0]   FPS_FLOOR  = 10'd1;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

   // Divider geometry: 32-bit dividend, 16-bit divisor, one bit per cycle
   localparam int DIV_STEPS = TIME_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Request to the shared divider
   typedef struct packed {
      logic               start;
      logic [TIME_W-1:0]  dividend;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;

   // Reply from the shared divider
   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/frps_if.sv
// ----------------------------------------------------------------------------
// frps_if
// Channel interfaces: frame request, pacing response and rate register write.
// ----------------------------------------------------------------------------
interface frps_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [frps_pkg::TIME_W-1:0] now_ms;

   modport source (output valid, output operation, output now_ms, input ready);
   modport sink   (input valid, input operation, input now_ms, output ready);
endinterface

interface frps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [frps_pkg::TIME_W-1:0]  wait_ms;
   logic [frps_pkg::TIME_W-1:0]  frame_delta_ms;
   logic                         window_done;
   logic [frps_pkg::COUNT_W-1:0] fps_seen;
   logic [frps_pkg::TIME_W-1:0]  avg_frame_ms;
   logic [frps_pkg::MIN_W-1:0]   min_frame_ms;
   logic [frps_pkg::TIME_W-1:0]  max_frame_ms;

   modport source (output valid, output wait_ms, output frame_delta_ms,
                   output window_done, output fps_seen, output avg_frame_ms,
                   output min_frame_ms, output max_frame_ms, input ready);
   modport sink   (input valid, input wait_ms, input frame_delta_ms,
                   input window_done, input fps_seen, input avg_frame_ms,
                   input min_frame_ms, input max_frame_ms, output ready);
endinterface

interface frps_csr_if;
   logic                       valid;
   logic                       ready;
   logic [frps_pkg::FPS_W-1:0] max_fps;

   modport source (output valid, output max_fps, input ready);
   modport sink   (input valid, input max_fps, output ready);
endinterface

// File: rtl/frps_div.sv
// ----------------------------------------------------------------------------
// frps_div
// Restoring radix-2 divider, 32-bit dividend by 16-bit divisor, one quotient
// bit per cycle. Done pulses for one cycle with the quotient valid.
// ----------------------------------------------------------------------------
module frps_div (
   input  logic                  clock,
   input  logic                  reset,
   input  frps_pkg::div_req_type req,
   output frps_pkg::div_rsp_type rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [frps_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [frps_pkg::COUNT_W-1:0]    rem_ff, rem_in;
   logic [frps_pkg::COUNT_W-1:0]    dsr_ff, dsr_in;
   logic [frps_pkg::TIME_W-1:0]     qr_ff, qr_in;

   logic [frps_pkg::COUNT_W:0]      trial;
   logic [frps_pkg::COUNT_W:0]      diff;
   logic                            fits;

   // One restoring step: shift in next dividend bit, try the subtract
   always_comb begin
      trial = {rem_ff, qr_ff[frps_pkg::TIME_W-1]};
      fits  = trial >= {1'b0, dsr_ff};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      qr_in   = qr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = req.divisor;
         qr_in   = req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[frps_pkg::COUNT_W-1:0] : trial[frps_pkg::COUNT_W-1:0];
         qr_in  = {qr_ff[frps_pkg::TIME_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == frps_pkg::DIV_CNT_W'(frps_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      qr_ff  <= qr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = qr_ff;

endmodule

// File: rtl/frame_rate_pacer_with_stats_core.sv
// ----------------------------------------------------------------------------
// frame_rate_pacer_with_stats_core
// Frame pacer: reports the wait to the next frame slot and keeps per-window
// interval statistics (count, floor average, minimum, maximum).
// ----------------------------------------------------------------------------
// Usage:
//   req_chan : one transaction per event; operation START opens a new window
//              at now_ms, FRAME reports a completed frame at now_ms.
//   rsp_chan : exactly one transaction per request, carrying the wait, the
//              post-delay frame delta and the last latched window statistics.
//   csr_chan : writes max_fps (0 acts as 1); always ready, write only while
//              no request is in flight.
// Sequencing:
//   START: ST_IDLE goes straight to ST_RESP with the response registered.
//   FRAME runs the shared 32-step divider once for the slot offset
//   (ST_OFS), evaluates the interval in ST_EVAL, and runs the divider a
//   second time for the average (ST_AVG) when the frame closes a window,
//   before ST_RESP. One request is in flight at a time and req_chan.ready
//   is low until the response is taken.
// Reset: synchronous, active high; max_fps returns to 60, all window state
//   and latched statistics clear, interval minimum goes to 1000.
// Stall: the response is held in registers while rsp_chan.ready is low and
//   no new request is taken until it is consumed.
// ----------------------------------------------------------------------------
module frame_rate_pacer_with_stats_core (
   input  logic       clock,
   input  logic       reset,
   frps_req_if.sink   req_chan,
   frps_rsp_if.source rsp_chan,
   frps_csr_if.sink   csr_chan
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_OFS  = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_AVG  = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Architectural state
   logic [frps_pkg::FPS_W-1:0]   fps_ff, fps_in;
   logic [frps_pkg::TIME_W-1:0]  wstart_ff, wstart_in;
   logic [frps_pkg::COUNT_W-1:0] frames_ff, frames_in;
   logic [frps_pkg::TIME_W-1:0]  last_ff, last_in;
   logic [frps_pkg::TIME_W-1:0]  sum_ff, sum_in;
   logic [frps_pkg::MIN_W-1:0]   min_ff, min_in;
   logic [frps_pkg::TIME_W-1:0]  max_ff, max_in;
   logic [frps_pkg::COUNT_W-1:0] lat_fps_ff, lat_fps_in;
   logic [frps_pkg::TIME_W-1:0]  lat_avg_ff, lat_avg_in;
   logic [frps_pkg::MIN_W-1:0]   lat_min_ff, lat_min_in;
   logic [frps_pkg::TIME_W-1:0]  lat_max_ff, lat_max_in;

   // Per-transaction working registers
   logic [frps_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [frps_pkg::TIME_W-1:0]  offset_ff, offset_in;
   logic [frps_pkg::TIME_W-1:0]  cur_ff, cur_in;
   logic [frps_pkg::TIME_W-1:0]  wait_ff, wait_in;
   logic [frps_pkg::TIME_W-1:0]  delta_ff, delta_in;
   logic                         done_ff, done_in;

   frps_pkg::div_req_type div_req;
   frps_pkg::div_rsp_type div_rsp;

   logic                         req_fire;
   logic [frps_pkg::FPS_W-1:0]   fps_eff;
   logic [frps_pkg::COUNT_W-1:0] count_next;
   logic [frps_pkg::TIME_W-1:0]  interval;
   logic [frps_pkg::TIME_W:0]    sum_wide;
   logic [frps_pkg::TIME_W-1:0]  sum_new;
   logic [frps_pkg::TIME_W-1:0]  elapsed;
   logic                         late;
   logic [frps_pkg::TIME_W-1:0]  elapsed_eff;
   logic [frps_pkg::TIME_W-1:0]  cur_val;

   assign req_fire = req_chan.valid && req_chan.ready;

   // Frame count and effective rate
   always_comb begin
      fps_eff    = (fps_ff == '0) ? frps_pkg::FPS_FLOOR : fps_ff;
      count_next = (frames_ff == frps_pkg::COUNT_MAX) ? frames_ff : frames_ff + 1'b1;
   end

   // Interval and slot arithmetic for the evaluate step
   always_comb begin
      interval    = now_ff - last_ff;
      sum_wide    = {1'b0, sum_ff} + {1'b0, interval};
      sum_new     = sum_wide[frps_pkg::TIME_W] ? '1 : sum_wide[frps_pkg::TIME_W-1:0];
      elapsed     = now_ff - wstart_ff;
      late        = elapsed < offset_ff;
      elapsed_eff = late ? offset_ff : elapsed;
      cur_val     = late ? (wstart_ff + offset_ff) : now_ff;
   end

   // Sequencer and state updates
   always_comb begin
      state_in   = state_ff;
      fps_in     = fps_ff;
      wstart_in  = wstart_ff;
      frames_in  = frames_ff;
      last_in    = last_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      lat_fps_in = lat_fps_ff;
      lat_avg_in = lat_avg_ff;
      lat_min_in = lat_min_ff;
      lat_max_in = lat_max_ff;
      now_in     = now_ff;
      offset_in  = offset_ff;
      cur_in     = cur_ff;
      wait_in    = wait_ff;
      delta_in   = delta_ff;
      done_in    = done_ff;

      div_req.start    = 1'b0;
      div_req.dividend = 32'(count_next) * frps_pkg::MS_PER_SEC;
      div_req.divisor  = frps_pkg::COUNT_W'(fps_eff);

      if (csr_chan.valid) begin
         fps_in = csr_chan.max_fps;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in = req_chan.now_ms;
               if (req_chan.operation == frps_pkg::OP_START) begin
                  wstart_in = req_chan.now_ms;
                  frames_in = '0;
                  wait_in   = '0;
                  delta_in  = '0;
                  done_in   = 1'b0;
                  state_in  = ST_RESP;
               end else begin
                  // slot offset = count * 1000 / fps
                  frames_in     = count_next;
                  div_req.start = 1'b1;
                  state_in      = ST_OFS;
               end
            end
         end
         ST_OFS: begin
            if (div_rsp.done) begin
               offset_in = div_rsp.quotient;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            sum_in = sum_new;
            if (interval <= {{(frps_pkg::TIME_W-frps_pkg::MIN_W){1'b0}}, min_ff}) begin
               min_in = interval[frps_pkg::MIN_W-1:0];
            end
            if (interval >= max_ff) begin
               max_in = interval;
            end
            wait_in  = late ? (offset_ff - elapsed) : '0;
            delta_in = cur_val - last_ff;
            last_in  = cur_val;
            cur_in   = cur_val;
            done_in  = 1'b0;
            if (elapsed_eff >= frps_pkg::WINDOW_MS) begin
               // window closes: average = sum / count
               div_req.start    = 1'b1;
               div_req.dividend = sum_new;
               div_req.divisor  = frames_ff;
               state_in         = ST_AVG;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_AVG: begin
            if (div_rsp.done) begin
               lat_fps_in = frames_ff;
               lat_avg_in = div_rsp.quotient;
               lat_min_in = min_ff;
               lat_max_in = max_ff;
               frames_in  = '0;
               min_in     = frps_pkg::MIN_RESET;
               max_in     = '0;
               sum_in     = '0;
               wstart_in  = cur_ff;
               done_in    = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fps_ff     <= frps_pkg::FPS_RESET;
         wstart_ff  <= '0;
         frames_ff  <= '0;
         last_ff    <= '0;
         sum_ff     <= '0;
         min_ff     <= frps_pkg::MIN_RESET;
         max_ff     <= '0;
         lat_fps_ff <= '0;
         lat_avg_ff <= '0;
         lat_min_ff <= '0;
         lat_max_ff <= '0;
      end else begin
         state_ff   <= state_in;
         fps_ff     <= fps_in;
         wstart_ff  <= wstart_in;
         frames_ff  <= frames_in;
         last_ff    <= last_in;
         sum_ff     <= sum_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         lat_fps_ff <= lat_fps_in;
         lat_avg_ff <= lat_avg_in;
         lat_min_ff <= lat_min_in;
         lat_max_ff <= lat_max_in;
      end
      now_ff    <= now_in;
      offset_ff <= offset_in;
      cur_ff    <= cur_in;
      wait_ff   <= wait_in;
      delta_ff  <= delta_in;
      done_ff   <= done_in;
   end

   // Shared divider
   frps_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Channel outputs
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid          = (state_ff == ST_RESP);
   assign rsp_chan.wait_ms        = wait_ff;
   assign rsp_chan.frame_delta_ms = delta_ff;
   assign rsp_chan.window_done    = done_ff;
   assign rsp_chan.fps_seen       = lat_fps_ff;
   assign rsp_chan.avg_frame_ms   = lat_avg_ff;
   assign rsp_chan.min_frame_ms   = lat_min_ff;
   assign rsp_chan.max_frame_ms   = lat_max_ff;

endmodule
